FILE: src/gkht_pkg.sv
// Package for the generational key handle table: sizes, codes, entry word
// and the command/status structs between controller and datapath.
// No dependencies.
package gkht_pkg;

    localparam int MAX_ENTRIES = 8192;
    localparam int INDEX_BITS  = 14;
    localparam int MAX_OWNERS  = 8;
    localparam int HANDLE_BITS = 32;
    localparam int GEN_W       = HANDLE_BITS - INDEX_BITS;
    localparam int ADDR_W      = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = 14;

    localparam logic [2:0] FN_ALLOC   = 3'd0;
    localparam logic [2:0] FN_LOOKUP  = 3'd1;
    localparam logic [2:0] FN_RELEASE = 3'd2;
    localparam logic [2:0] FN_PURGE   = 3'd3;
    localparam logic [2:0] FN_PURGE_A = 3'd4;
    localparam logic [2:0] FN_COUNT   = 3'd5;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FAIL = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    localparam logic [2:0] TYPE_X25519 = 3'd0;
    localparam logic [2:0] TYPE_PREKEY = 3'd1;
    localparam logic [2:0] TYPE_LAST   = 3'd4;

    localparam logic [2:0] RES_OK     = 3'd0;
    localparam logic [2:0] RES_FAIL   = 3'd1;
    localparam logic [2:0] RES_FULL   = 3'd2;
    localparam logic [2:0] RES_ALLOC  = 3'd3;
    localparam logic [2:0] RES_LOOKUP = 3'd4;
    localparam logic [2:0] RES_COUNT  = 3'd5;

    typedef struct packed {
        logic             valid;
        logic [2:0]       kind;
        logic [2:0]       owner;
        logic [GEN_W-1:0] gen;
    } t_entry;

    typedef struct packed {
        logic       cap;
        logic       clr_addr;
        logic       inc_addr;
        logic       rd_addr;
        logic       rd_hnd;
        logic       wr_alloc;
        logic       wr_zero_addr;
        logic       wr_zero_hnd;
        logic       dec_live;
        logic       load_out;
        logic [2:0] res_code;
    } t_cmd;

    typedef struct packed {
        logic [2:0] func;
        logic       bad_alloc;
        logic       bad_hidx;
        logic       last;
        logic       ent_free;
        logic       gen_hit;
        logic       type_ok;
        logic       slot_ok;
        logic       owner_hit;
        logic       out_free;
    } t_sts;

endpackage

FILE: src/gkht_dp.sv
// Datapath of the key handle table: request capture, entry memory,
// generation counter, live count and output register. Uses gkht_pkg.
module gkht_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  gkht_pkg::t_cmd       i_cmd,
    output gkht_pkg::t_sts       o_sts,
    input  logic [2:0]           i_func,
    input  logic [31:0]          i_handle,
    input  logic [2:0]           i_slot_index,
    input  logic [2:0]           i_key_type,
    input  logic [2:0]           i_want_type,
    input  logic                 i_exact_type,
    input  logic                 i_check_slot,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [1:0]           o_status,
    output logic [31:0]          o_new_handle,
    output logic [12:0]          o_entry_index,
    output logic [2:0]           o_entry_type,
    output logic [2:0]           o_entry_slot,
    output logic [13:0]          o_live_count
);

    logic [2:0]  r_func;
    logic [31:0] r_handle;
    logic [2:0]  r_slot;
    logic [2:0]  r_ktype;
    logic [2:0]  r_want;
    logic        r_exact;
    logic        r_chk;

    logic [gkht_pkg::ADDR_W:0]       r_addr;
    gkht_pkg::t_entry                r_rdata;
    gkht_pkg::t_entry                mem [gkht_pkg::MAX_ENTRIES];
    logic [gkht_pkg::GEN_W-1:0]      r_gen_ctr;
    logic [gkht_pkg::GEN_W-1:0]      r_res_gen;
    logic [gkht_pkg::GEN_W-1:0]      n_gen_ctr;
    logic [gkht_pkg::CNT_W-1:0]      r_live;

    logic [gkht_pkg::INDEX_BITS-1:0] hidx;
    logic [gkht_pkg::ADDR_W-1:0]     hent;
    logic [gkht_pkg::INDEX_BITS-1:0] alloc_low;
    logic                            we;
    logic [gkht_pkg::ADDR_W-1:0]     waddr;
    gkht_pkg::t_entry                wdata;
    logic [gkht_pkg::ADDR_W-1:0]     raddr;

    logic        r_out_valid;
    logic [1:0]  r_status;
    logic [31:0] r_nh;
    logic [12:0] r_eidx;
    logic [2:0]  r_etype;
    logic [2:0]  r_eslot;
    logic [13:0] r_cnt;
    logic [1:0]  n_status;
    logic [31:0] n_nh;
    logic [12:0] n_eidx;
    logic [2:0]  n_etype;
    logic [2:0]  n_eslot;
    logic [13:0] n_cnt;

    assign hidx      = r_handle[gkht_pkg::INDEX_BITS-1:0];
    assign hent      = gkht_pkg::ADDR_W'(hidx - 1'b1);
    assign alloc_low = gkht_pkg::INDEX_BITS'(r_addr + 1'b1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_func   <= i_func;
            r_handle <= i_handle;
            r_slot   <= i_slot_index;
            r_ktype  <= i_key_type;
            r_want   <= i_want_type;
            r_exact  <= i_exact_type;
            r_chk    <= i_check_slot;
        end
    end

    // memory write and registered read
    always_comb begin
        we    = i_cmd.wr_alloc | i_cmd.wr_zero_addr | i_cmd.wr_zero_hnd;
        waddr = i_cmd.wr_zero_hnd ? hent : r_addr[gkht_pkg::ADDR_W-1:0];
        wdata = '0;
        if (i_cmd.wr_alloc) begin
            wdata.valid = 1'b1;
            wdata.kind  = r_ktype;
            wdata.owner = r_slot;
            wdata.gen   = r_gen_ctr;
        end
        raddr = i_cmd.rd_hnd ? hent : r_addr[gkht_pkg::ADDR_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (i_cmd.rd_addr | i_cmd.rd_hnd) begin
            r_rdata <= mem[raddr];
        end
    end

    always_comb begin
        n_gen_ctr = r_gen_ctr + 1'b1;
        if (n_gen_ctr == '0) begin
            n_gen_ctr = gkht_pkg::GEN_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr    <= '0;
            r_gen_ctr <= gkht_pkg::GEN_W'(1);
            r_live    <= '0;
        end else begin
            if (i_cmd.clr_addr) begin
                r_addr <= '0;
            end else if (i_cmd.inc_addr) begin
                r_addr <= r_addr + 1'b1;
            end
            if (i_cmd.wr_alloc) begin
                r_gen_ctr <= n_gen_ctr;
                r_live    <= r_live + 1'b1;
            end else if (i_cmd.dec_live && r_live != '0) begin
                r_live <= r_live - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_alloc) begin
            r_res_gen <= r_gen_ctr;
        end
    end

    // status toward the controller
    always_comb begin
        o_sts.func      = r_func;
        o_sts.bad_alloc = (r_ktype > gkht_pkg::TYPE_LAST) ||
                          (32'(r_slot) >= gkht_pkg::MAX_OWNERS);
        o_sts.bad_hidx  = (hidx == '0) || (32'(hidx) > gkht_pkg::MAX_ENTRIES);
        o_sts.last      = (32'(r_addr) == gkht_pkg::MAX_ENTRIES - 1);
        o_sts.ent_free  = !r_rdata.valid;
        o_sts.gen_hit   = r_rdata.valid &&
                          (r_rdata.gen == r_handle[31:gkht_pkg::INDEX_BITS]);
        o_sts.type_ok   = (r_rdata.kind == r_want) ||
                          (!r_exact && r_want == gkht_pkg::TYPE_X25519 &&
                           r_rdata.kind == gkht_pkg::TYPE_PREKEY);
        o_sts.slot_ok   = !r_chk || (r_rdata.owner == r_slot);
        o_sts.owner_hit = r_rdata.valid && (r_rdata.owner == r_slot);
        o_sts.out_free  = !r_out_valid || !i_out_stall;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_comb begin
        n_status = gkht_pkg::ST_FAIL;
        n_nh     = '0;
        n_eidx   = '0;
        n_etype  = '0;
        n_eslot  = '0;
        n_cnt    = '0;
        case (i_cmd.res_code)
            gkht_pkg::RES_OK: begin
                n_status = gkht_pkg::ST_OK;
            end
            gkht_pkg::RES_FULL: begin
                n_status = gkht_pkg::ST_FULL;
            end
            gkht_pkg::RES_ALLOC: begin
                n_status = gkht_pkg::ST_OK;
                n_nh     = {r_res_gen, alloc_low};
                n_eidx   = 13'(r_addr);
                n_etype  = r_ktype;
                n_eslot  = r_slot;
            end
            gkht_pkg::RES_LOOKUP: begin
                n_status = gkht_pkg::ST_OK;
                n_eidx   = 13'(hent);
                n_etype  = r_rdata.kind;
                n_eslot  = r_rdata.owner;
            end
            gkht_pkg::RES_COUNT: begin
                n_status = gkht_pkg::ST_OK;
                n_cnt    = 14'(r_live);
            end
            default: begin
                n_status = gkht_pkg::ST_FAIL;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_status <= n_status;
            r_nh     <= n_nh;
            r_eidx   <= n_eidx;
            r_etype  <= n_etype;
            r_eslot  <= n_eslot;
            r_cnt    <= n_cnt;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_new_handle  = r_nh;
    assign o_entry_index = r_eidx;
    assign o_entry_type  = r_etype;
    assign o_entry_slot  = r_eslot;
    assign o_live_count  = r_cnt;

endmodule

FILE: src/gkht_ctrl.sv
// Controller of the key handle table: sequences clearing, scans, lookups
// and result hand-off through datapath commands. Uses gkht_pkg.
module gkht_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  gkht_pkg::t_sts i_sts,
    output gkht_pkg::t_cmd o_cmd
);

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_DECODE = 4'd2;
    localparam logic [3:0] S_A_RD   = 4'd3;
    localparam logic [3:0] S_A_CHK  = 4'd4;
    localparam logic [3:0] S_H_CHK  = 4'd5;
    localparam logic [3:0] S_P_RD   = 4'd6;
    localparam logic [3:0] S_P_CHK  = 4'd7;
    localparam logic [3:0] S_RESP   = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic [2:0] r_code;
    logic [2:0] n_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_code  <= gkht_pkg::RES_FAIL;
        end else begin
            r_state <= n_state;
            r_code  <= n_code;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state        = r_state;
        n_code         = r_code;
        o_cmd          = '0;
        o_cmd.res_code = r_code;
        case (r_state)
            S_CLEAR: begin
                o_cmd.wr_zero_addr = 1'b1;
                if (i_sts.last) begin
                    o_cmd.clr_addr = 1'b1;
                    n_state        = S_IDLE;
                end else begin
                    o_cmd.inc_addr = 1'b1;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.cap = 1'b1;
                    n_state   = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.clr_addr = 1'b1;
                case (i_sts.func)
                    gkht_pkg::FN_ALLOC: begin
                        if (i_sts.bad_alloc) begin
                            n_code  = gkht_pkg::RES_FAIL;
                            n_state = S_RESP;
                        end else begin
                            n_state = S_A_RD;
                        end
                    end
                    gkht_pkg::FN_LOOKUP, gkht_pkg::FN_RELEASE: begin
                        if (i_sts.bad_hidx) begin
                            n_code  = gkht_pkg::RES_FAIL;
                            n_state = S_RESP;
                        end else begin
                            o_cmd.rd_hnd = 1'b1;
                            n_state      = S_H_CHK;
                        end
                    end
                    gkht_pkg::FN_PURGE, gkht_pkg::FN_PURGE_A: begin
                        n_state = S_P_RD;
                    end
                    gkht_pkg::FN_COUNT: begin
                        n_code  = gkht_pkg::RES_COUNT;
                        n_state = S_RESP;
                    end
                    default: begin
                        n_code  = gkht_pkg::RES_FAIL;
                        n_state = S_RESP;
                    end
                endcase
            end
            S_A_RD: begin
                o_cmd.rd_addr = 1'b1;
                n_state       = S_A_CHK;
            end
            S_A_CHK: begin
                if (i_sts.ent_free) begin
                    o_cmd.wr_alloc = 1'b1;
                    n_code         = gkht_pkg::RES_ALLOC;
                    n_state        = S_RESP;
                end else if (i_sts.last) begin
                    n_code  = gkht_pkg::RES_FULL;
                    n_state = S_RESP;
                end else begin
                    o_cmd.inc_addr = 1'b1;
                    n_state        = S_A_RD;
                end
            end
            S_H_CHK: begin
                n_code  = gkht_pkg::RES_FAIL;
                n_state = S_RESP;
                if (i_sts.gen_hit) begin
                    if (i_sts.func == gkht_pkg::FN_RELEASE) begin
                        o_cmd.wr_zero_hnd = 1'b1;
                        o_cmd.dec_live    = 1'b1;
                        n_code            = gkht_pkg::RES_OK;
                    end else if (i_sts.type_ok && i_sts.slot_ok) begin
                        n_code = gkht_pkg::RES_LOOKUP;
                    end
                end
            end
            S_P_RD: begin
                o_cmd.rd_addr = 1'b1;
                n_state       = S_P_CHK;
            end
            S_P_CHK: begin
                // drop every entry of the slot, or every entry at all
                if (i_sts.func == gkht_pkg::FN_PURGE_A || i_sts.owner_hit) begin
                    o_cmd.wr_zero_addr = 1'b1;
                    o_cmd.dec_live     = !i_sts.ent_free;
                end
                if (i_sts.last) begin
                    n_code  = gkht_pkg::RES_OK;
                    n_state = S_RESP;
                end else begin
                    o_cmd.inc_addr = 1'b1;
                    n_state        = S_P_RD;
                end
            end
            S_RESP: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

FILE: src/generational_key_handle_table_unit.sv
// Top level of the generational key handle table.
// Joins gkht_ctrl and gkht_dp; uses gkht_pkg.
//
// The unit keeps 8192 key entries (valid, type, owning slot, 18-bit
// generation) in one single-port-write, registered-read memory and serves
// one request at a time. After reset it runs a clearing pass over all 8192
// entries, one entry per cycle, with o_in_stall high; then it takes requests.
// Count and refused requests go from decode straight to the result register;
// lookup and release read the one entry that the handle names. Allocate scans
// from index 0 up to the first free entry, and both purges sweep the whole
// table, since each entry is read, checked and rewritten through the one
// memory port. After the result is loaded the unit returns to idle and takes
// the next request. The result register lets the next request be accepted
// while the previous result still waits to be taken.
module generational_key_handle_table_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_func,
    input  logic [31:0] i_handle,
    input  logic [2:0]  i_slot_index,
    input  logic [2:0]  i_key_type,
    input  logic [2:0]  i_want_type,
    input  logic        i_exact_type,
    input  logic        i_check_slot,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [31:0] o_new_handle,
    output logic [12:0] o_entry_index,
    output logic [2:0]  o_entry_type,
    output logic [2:0]  o_entry_slot,
    output logic [13:0] o_live_count
);

    gkht_pkg::t_cmd cmd;
    gkht_pkg::t_sts sts;

    // sequencer: clearing pass, scans and result hand-off
    gkht_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // entry memory, counters and output register
    gkht_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_func        (i_func),
        .i_handle      (i_handle),
        .i_slot_index  (i_slot_index),
        .i_key_type    (i_key_type),
        .i_want_type   (i_want_type),
        .i_exact_type  (i_exact_type),
        .i_check_slot  (i_check_slot),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_new_handle  (o_new_handle),
        .o_entry_index (o_entry_index),
        .o_entry_type  (o_entry_type),
        .o_entry_slot  (o_entry_slot),
        .o_live_count  (o_live_count)
    );

endmodule

FILE: bench/tb.sv
// Self-checking bench for generational_key_handle_table_unit: a predictor of the
// key table checks every result in order. Depends on gkht_pkg and the unit RTL.
`timescale 1ns / 1ps

module tb;

    // Function codes that the unit does not implement; both must be refused.
    localparam logic [2:0] FN_UNUSED_LO  = 3'd6;
    localparam logic [2:0] FN_UNUSED_HI  = 3'd7;
    localparam logic [2:0] TYPE_BAD      = 3'd5;
    localparam logic [2:0] TYPE_ED25519  = 3'd2;
    localparam logic [2:0] TYPE_MLKEM768 = 3'd3;
    localparam int         RAND_REQS     = 1820;
    localparam int         CYCLE_LIMIT   = 4000000;
    localparam int         HOT_ENTRIES   = 64;

    typedef struct packed {
        logic [2:0]  func;
        logic [31:0] handle;
        logic [2:0]  slot;
        logic [2:0]  ktype;
        logic [2:0]  want;
        logic        exact;
        logic        chk;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] new_handle;
        logic [12:0] index;
        logic [2:0]  etype;
        logic [2:0]  eslot;
        logic [13:0] count;
    } t_rsp;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [2:0]  i_func = '0;
    logic [31:0] i_handle = '0;
    logic [2:0]  i_slot_index = '0;
    logic [2:0]  i_key_type = '0;
    logic [2:0]  i_want_type = '0;
    logic        i_exact_type = 1'b0;
    logic        i_check_slot = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [1:0]  o_status;
    logic [31:0] o_new_handle;
    logic [12:0] o_entry_index;
    logic [2:0]  o_entry_type;
    logic [2:0]  o_entry_slot;
    logic [13:0] o_live_count;

    generational_key_handle_table_unit u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_func       (i_func),
        .i_handle     (i_handle),
        .i_slot_index (i_slot_index),
        .i_key_type   (i_key_type),
        .i_want_type  (i_want_type),
        .i_exact_type (i_exact_type),
        .i_check_slot (i_check_slot),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_status     (o_status),
        .o_new_handle (o_new_handle),
        .o_entry_index(o_entry_index),
        .o_entry_type (o_entry_type),
        .o_entry_slot (o_entry_slot),
        .o_live_count (o_live_count)
    );

    always #5 i_clk = ~i_clk;

    // Shadow of the key table, updated as each request is accepted.
    logic                       key_live  [gkht_pkg::MAX_ENTRIES];
    logic [2:0]                 key_kind  [gkht_pkg::MAX_ENTRIES];
    logic [2:0]                 key_owner [gkht_pkg::MAX_ENTRIES];
    logic [gkht_pkg::GEN_W-1:0] key_gen   [gkht_pkg::MAX_ENTRIES];
    logic [gkht_pkg::GEN_W-1:0] gen_stamp;
    logic [13:0]                live_keys;

    t_req pending_reqs[$];
    t_rsp expected_rsps[$];
    int   errors = 0;
    int   cycles = 0;
    int   sender_idle_pct = 0;
    int   stall_pct = 0;

    task automatic report(input string what, input logic [31:0] got,
                          input logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // Entry named by a handle, or -1 when the handle is dead.
    function automatic int decode_handle(input logic [31:0] h);
        logic [gkht_pkg::INDEX_BITS-1:0] idx;
        idx = h[gkht_pkg::INDEX_BITS-1:0];
        if (idx == 0 || idx > gkht_pkg::MAX_ENTRIES) return -1;
        if (!key_live[idx-1] || key_gen[idx-1] != h[31:gkht_pkg::INDEX_BITS]) return -1;
        return idx - 1;
    endfunction

    function automatic void drop_key(input int e);
        if (key_live[e] && live_keys > 0) live_keys--;
        key_live[e]  = 1'b0;
        key_kind[e]  = '0;
        key_owner[e] = '0;
        key_gen[e]   = '0;
    endfunction

    function automatic logic [31:0] handle_of(input int e);
        return {key_gen[e], gkht_pkg::INDEX_BITS'(e + 1)};
    endfunction

    // Apply one request to the shadow table and return the result it must give.
    function automatic t_rsp apply_request(input t_req r);
        t_rsp o;
        int   e;
        o = '0;
        o.status = gkht_pkg::ST_FAIL;
        case (r.func)
            gkht_pkg::FN_ALLOC: begin
                if (r.ktype <= gkht_pkg::TYPE_LAST && r.slot < gkht_pkg::MAX_OWNERS) begin
                    e = 0;
                    while (e < gkht_pkg::MAX_ENTRIES && key_live[e]) e++;
                    if (e == gkht_pkg::MAX_ENTRIES) begin
                        o.status = gkht_pkg::ST_FULL;
                    end else begin
                        key_live[e]  = 1'b1;
                        key_kind[e]  = r.ktype;
                        key_owner[e] = r.slot;
                        key_gen[e]   = gen_stamp;
                        live_keys++;
                        gen_stamp++;
                        if (gen_stamp == '0) gen_stamp = gkht_pkg::GEN_W'(1);
                        o.status     = gkht_pkg::ST_OK;
                        o.new_handle = handle_of(e);
                        o.index      = 13'(e);
                        o.etype      = r.ktype;
                        o.eslot      = r.slot;
                    end
                end
            end
            gkht_pkg::FN_LOOKUP: begin
                e = decode_handle(r.handle);
                if (e >= 0 && (key_kind[e] == r.want ||
                        (!r.exact && r.want == gkht_pkg::TYPE_X25519
                        && key_kind[e] == gkht_pkg::TYPE_PREKEY))
                        && (!r.chk || key_owner[e] == r.slot))
                begin
                    o.status = gkht_pkg::ST_OK;
                    o.index  = 13'(e);
                    o.etype  = key_kind[e];
                    o.eslot  = key_owner[e];
                end
            end
            gkht_pkg::FN_RELEASE: begin
                e = decode_handle(r.handle);
                if (e >= 0) begin
                    drop_key(e);
                    o.status = gkht_pkg::ST_OK;
                end
            end
            gkht_pkg::FN_PURGE: begin
                for (int k = 0; k < gkht_pkg::MAX_ENTRIES; k++)
                    if (key_live[k] && key_owner[k] == r.slot) drop_key(k);
                o.status = gkht_pkg::ST_OK;
            end
            gkht_pkg::FN_PURGE_A: begin
                for (int k = 0; k < gkht_pkg::MAX_ENTRIES; k++) drop_key(k);
                o.status = gkht_pkg::ST_OK;
            end
            gkht_pkg::FN_COUNT: begin
                o.status = gkht_pkg::ST_OK;
                o.count  = live_keys;
            end
            default: ;
        endcase
        return o;
    endfunction

    // Driver: predict each request as it is accepted, then present the next
    // one from the queue unless this cycle is chosen as a sender gap.
    always @(posedge i_clk) begin
        t_req r;
        logic take_next;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            take_next = !i_in_valid || !o_in_stall;
            if (i_in_valid && !o_in_stall)
                expected_rsps.push_back(apply_request({i_func, i_handle, i_slot_index,
                    i_key_type, i_want_type, i_exact_type, i_check_slot}));
            if (take_next) begin
                if (pending_reqs.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
                    r = pending_reqs.pop_front();
                    i_in_valid   <= 1'b1;
                    i_func       <= r.func;
                    i_handle     <= r.handle;
                    i_slot_index <= r.slot;
                    i_key_type   <= r.ktype;
                    i_want_type  <= r.want;
                    i_exact_type <= r.exact;
                    i_check_slot <= r.chk;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each taken result with the oldest expectation, and
    // randomize the output stall. Also enforce the cycle limit.
    always @(posedge i_clk) begin
        t_rsp x;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("RESULT: ERROR");
            $finish;
        end
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_rsps.size() == 0) begin
                    report("unexpected result", 32'(o_status), '0);
                end else begin
                    x = expected_rsps.pop_front();
                    if (o_status !== x.status)
                        report("status", 32'(o_status), 32'(x.status));
                    if (o_new_handle !== x.new_handle)
                        report("new_handle", o_new_handle, x.new_handle);
                    if (o_entry_index !== x.index)
                        report("entry_index", 32'(o_entry_index), 32'(x.index));
                    if (o_entry_type !== x.etype)
                        report("entry_type", 32'(o_entry_type), 32'(x.etype));
                    if (o_entry_slot !== x.eslot)
                        report("entry_slot", 32'(o_entry_slot), 32'(x.eslot));
                    if (o_live_count !== x.count)
                        report("live_count", 32'(o_live_count), 32'(x.count));
                end
            end
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic send(input logic [2:0] f, input logic [31:0] h, input logic [2:0] s,
                        input logic [2:0] kt, input logic [2:0] wt, input logic ex,
                        input logic ck);
        while (pending_reqs.size() >= 2) @(posedge i_clk);
        pending_reqs.push_back({f, h, s, kt, wt, ex, ck});
    endtask

    // Hold until every request has been taken and every result checked.
    task automatic drain();
        while (pending_reqs.size() > 0 || i_in_valid || expected_rsps.size() > 0)
            @(posedge i_clk);
    endtask

    // Pick a handle: mostly one of the low, busy entries (live or dead),
    // sometimes with one bit flipped, sometimes fully random.
    function automatic logic [31:0] pick_handle();
        int          e;
        int          b;
        logic [31:0] h;
        e = $urandom_range(HOT_ENTRIES - 1);
        b = $urandom_range(31);
        h = key_live[e] ? handle_of(e)
                        : {$urandom_range(3) == 0 ? gkht_pkg::GEN_W'($urandom) : gen_stamp,
                           gkht_pkg::INDEX_BITS'(e + 1)};
        case ($urandom_range(9))
            0: h = $urandom;
            1: h[b] = ~h[b];
            default: ;
        endcase
        return h;
    endfunction

    initial begin
        logic [31:0] h;
        int          roll;
        for (int k = 0; k < gkht_pkg::MAX_ENTRIES; k++) begin
            key_live[k] = 1'b0; key_kind[k] = '0; key_owner[k] = '0; key_gen[k] = '0;
        end
        gen_stamp = gkht_pkg::GEN_W'(1);
        live_keys = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: one key of every type, owners at both ends.
        send(gkht_pkg::FN_ALLOC, '0, 3'd0, gkht_pkg::TYPE_X25519, '0, 1'b0, 1'b0);
        send(gkht_pkg::FN_ALLOC, '0, 3'd7, gkht_pkg::TYPE_PREKEY, '0, 1'b0, 1'b0);
        send(gkht_pkg::FN_ALLOC, '0, 3'd3, TYPE_ED25519, '0, 1'b0, 1'b0);
        send(gkht_pkg::FN_ALLOC, '0, 3'd5, TYPE_MLKEM768, '0, 1'b0, 1'b0);
        send(gkht_pkg::FN_ALLOC, '0, 3'd1, gkht_pkg::TYPE_LAST, '0, 1'b0, 1'b0);
        send(gkht_pkg::FN_ALLOC, '0, 3'd2, TYPE_BAD, '0, 1'b0, 1'b0);
        send(gkht_pkg::FN_COUNT, 32'hFFFF_FFFF, 3'd7, 3'd7, 3'd7, 1'b1, 1'b1);
        drain();
        // Exact hit, prekey serving x25519, same refused when exact, type miss,
        // slot check pass and fail.
        send(gkht_pkg::FN_LOOKUP, handle_of(0), 3'd0, '0, gkht_pkg::TYPE_X25519, 1'b1, 1'b1);
        send(gkht_pkg::FN_LOOKUP, handle_of(1), 3'd7, '0, gkht_pkg::TYPE_X25519, 1'b0, 1'b1);
        send(gkht_pkg::FN_LOOKUP, handle_of(1), 3'd7, '0, gkht_pkg::TYPE_X25519, 1'b1, 1'b0);
        send(gkht_pkg::FN_LOOKUP, handle_of(2), 3'd3, '0, gkht_pkg::TYPE_LAST, 1'b1, 1'b0);
        send(gkht_pkg::FN_LOOKUP, handle_of(4), 3'd6, '0, gkht_pkg::TYPE_LAST, 1'b1, 1'b1);
        // Dead handles: index zero, index out of range, wrong generation.
        send(gkht_pkg::FN_LOOKUP, 32'h0000_4000, '0, '0, '0, 1'b0, 1'b0);
        send(gkht_pkg::FN_LOOKUP, 32'hFFFF_FFFF, '0, '0, '0, 1'b0, 1'b0);
        send(gkht_pkg::FN_RELEASE, handle_of(3) ^ 32'h8000_0000, '0, '0, '0, 1'b0, 1'b0);
        send(gkht_pkg::FN_RELEASE, handle_of(3), '0, '0, '0, 1'b0, 1'b0);
        send(gkht_pkg::FN_RELEASE, handle_of(3), '0, '0, '0, 1'b0, 1'b0);
        send(FN_UNUSED_LO, '0, '0, '0, '0, 1'b0, 1'b0);
        send(FN_UNUSED_HI, 32'hFFFF_FFFF, 3'd7, 3'd7, 3'd7, 1'b1, 1'b1);
        send(gkht_pkg::FN_PURGE, '0, 3'd7, '0, '0, 1'b0, 1'b0);
        send(gkht_pkg::FN_PURGE, '0, 3'd4, '0, '0, 1'b0, 1'b0);
        send(gkht_pkg::FN_COUNT, '0, '0, '0, '0, 1'b0, 1'b0);
        send(gkht_pkg::FN_PURGE_A, '0, '0, '0, '0, 1'b0, 1'b0);
        send(gkht_pkg::FN_COUNT, '0, '0, '0, '0, 1'b0, 1'b0);
        drain();

        // Random: mostly allocate / lookup / release on a small working set,
        // rare purges since each one sweeps the whole table.
        for (int n = 0; n < RAND_REQS; n++) begin
            case (n * 5 / RAND_REQS)
                0: begin sender_idle_pct = 0;  stall_pct = 0;  end
                1: begin sender_idle_pct = 64; stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  stall_pct = 64; end
                3: begin sender_idle_pct = 34; stall_pct = 34; end
                default: begin sender_idle_pct = 0; stall_pct = 0; end
            endcase
            roll = $urandom_range(999);
            h = pick_handle();
            if (roll < 12)
                send(gkht_pkg::FN_PURGE, h, 3'($urandom), 3'($urandom), 3'($urandom),
                     1'($urandom), 1'($urandom));
            else if (roll < 16)
                send(gkht_pkg::FN_PURGE_A, h, 3'($urandom), '0, '0, 1'b0, 1'b0);
            else if (roll < 40)
                send(roll[0] ? FN_UNUSED_LO : FN_UNUSED_HI, h, 3'($urandom), 3'($urandom),
                     3'($urandom), 1'($urandom), 1'($urandom));
            else if (roll < 100)
                send(gkht_pkg::FN_COUNT, h, 3'($urandom), 3'($urandom), 3'($urandom),
                     1'($urandom), 1'($urandom));
            else if (roll < (live_keys > 40 ? 250 : 450))
                send(gkht_pkg::FN_ALLOC, h, 3'($urandom),
                     $urandom_range(19) == 0 ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4)),
                     3'($urandom), 1'($urandom), 1'($urandom));
            else if (roll < 700)
                send(gkht_pkg::FN_RELEASE, h, 3'($urandom), 3'($urandom), 3'($urandom),
                     1'($urandom), 1'($urandom));
            else
                send(gkht_pkg::FN_LOOKUP, h, 3'($urandom), 3'($urandom),
                     $urandom_range(9) == 0 ? 3'($urandom) : 3'($urandom_range(4)),
                     1'($urandom), 1'($urandom));
        end
        drain();
        repeat (64) @(posedge i_clk);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
